@@ sv/fgr_pkg.sv @@
`timescale 1ns / 1ps

package fgr_pkg;

   // operand width of numerator and denominator
   localparam int VALUE_WIDTH = 32;
   // stream data width: both fields, whole bytes
   localparam int DATA_WIDTH  = 2 * VALUE_WIDTH;
   // bit counter for the divider and the common power of two
   localparam int CNT_WIDTH   = $clog2(VALUE_WIDTH);

   typedef enum logic [2:0] {
      S_IDLE,
      S_GCD,
      S_DIV_NUM,
      S_SWAP,
      S_DIV_DEN,
      S_OUT
   } fgr_state_type;

   typedef enum logic {
      DIV_SEL_MAG,
      DIV_SEL_DEN
   } fgr_div_sel_type;

   typedef struct packed {
      logic            load;
      logic            gcd_step;
      logic            div_init;
      fgr_div_sel_type div_sel;
      logic            div_step;
      logic            save_num;
      logic            load_out;
   } fgr_cmd_type;

   typedef struct packed {
      logic gcd_done;
      logic both_zero;
      logic div_last;
   } fgr_status_type;

endpackage

@@ sv/fraction_gcd_reducer.sv @@
`timescale 1ns / 1ps

// channel  | direction | handshake              | payload
// ---------+-----------+------------------------+------------------------------------
// req      | in        | req_tvalid/req_tready  | req_tdata: numerator, denominator
// rsp      | out       | rsp_tvalid/rsp_tready  | rsp_tdata: reduced num, reduced den
//
// one item at a time: load in the idle state, the binary gcd loop, then two restoring divisions,
// a swap state and an output state; the divisions are skipped when both inputs are zero
// reset is synchronous, active high, and clears only the controller state
// and the result valid flag
// a finished result waits in its output register; the next word is taken
// meanwhile, and the block stalls at the end of that item only if rsp is blocked

module fraction_gcd_reducer (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   // [31:0] numerator (signed), [63:32] denominator
   input  logic [fgr_pkg::DATA_WIDTH-1:0] req_tdata,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   // [31:0] reduced_numerator (signed), [63:32] reduced_denominator
   output logic [fgr_pkg::DATA_WIDTH-1:0] rsp_tdata
);
   import fgr_pkg::*;

   fgr_cmd_type    cmd;
   fgr_status_type status;

   // sequencer: accepts a word, walks gcd and both divisions (none for a zero pair), loads the result
   fgr_controller u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd),
      .status     (status)
   );

   // operand registers, gcd step logic, shared divider and result register
   fgr_datapath u_dp (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .status   (status),
      .in_data  (req_tdata),
      .out_data (rsp_tdata)
   );

endmodule

@@ sv/fgr_datapath.sv @@
`timescale 1ns / 1ps

module fgr_datapath (
   input  logic                        clock,
   input  logic                        reset,
   input  fgr_pkg::fgr_cmd_type        cmd,
   output fgr_pkg::fgr_status_type     status,
   input  logic [fgr_pkg::DATA_WIDTH-1:0] in_data,
   output logic [fgr_pkg::DATA_WIDTH-1:0] out_data
);
   import fgr_pkg::*;

   localparam int W = VALUE_WIDTH;

   logic [W-1:0]         a_ff, a_in;
   logic [W-1:0]         b_ff, b_in;
   logic [CNT_WIDTH-1:0] k_ff, k_in;
   logic                 neg_ff, neg_in;
   logic [W-1:0]         mag_ff, mag_in;
   logic [W-1:0]         den_ff, den_in;
   logic [W-1:0]         g_ff, g_in;
   logic [W-1:0]         quo_ff, quo_in;
   logic [W-1:0]         rem_ff, rem_in;
   logic [CNT_WIDTH-1:0] cnt_ff, cnt_in;
   logic [W-1:0]         qnum_ff, qnum_in;
   logic [DATA_WIDTH-1:0] out_ff, out_in;

   logic [W-1:0] num_raw;
   logic [W-1:0] num_mag;
   logic [W:0]   ab_diff;
   logic [W:0]   rem_sh;
   logic [W:0]   rem_sub;
   logic         rem_ge;
   logic [W-1:0] qnum_neg;

   assign num_raw = in_data[W-1:0];
   assign num_mag = num_raw[W-1] ? (~num_raw + {{(W-1){1'b0}}, 1'b1}) : num_raw;

   // gcd ends when the values meet or one is zero; a|b is then the gcd without its common power of two
   assign status.gcd_done  = (a_ff == b_ff) || (a_ff == '0) || (b_ff == '0);
   assign status.both_zero = ((a_ff | b_ff) == '0);
   assign status.div_last  = (cnt_ff == CNT_WIDTH'(W - 1));

   assign ab_diff = {1'b0, a_ff} - {1'b0, b_ff};

   assign rem_sh  = {rem_ff, quo_ff[W-1]};
   assign rem_sub = rem_sh - {1'b0, g_ff};
   assign rem_ge  = !rem_sub[W];

   assign qnum_neg = ~qnum_ff + {{(W-1){1'b0}}, 1'b1};

   always_comb begin
      a_in    = a_ff;
      b_in    = b_ff;
      k_in    = k_ff;
      neg_in  = neg_ff;
      mag_in  = mag_ff;
      den_in  = den_ff;
      g_in    = g_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      qnum_in = qnum_ff;
      out_in  = out_ff;

      if (cmd.load) begin
         neg_in = num_raw[W-1];
         mag_in = num_mag;
         den_in = in_data[DATA_WIDTH-1:W];
         a_in   = num_mag;
         b_in   = in_data[DATA_WIDTH-1:W];
         k_in   = '0;
      end

      // binary gcd, one halving or subtract step a cycle
      if (cmd.gcd_step) begin
         if (status.gcd_done) begin
            g_in = (a_ff | b_ff) << k_ff;
         end else begin
            priority if (!a_ff[0] && !b_ff[0]) begin
               a_in = a_ff >> 1;
               b_in = b_ff >> 1;
               k_in = k_ff + CNT_WIDTH'(1);
            end else if (!a_ff[0]) begin
               a_in = a_ff >> 1;
            end else if (!b_ff[0]) begin
               b_in = b_ff >> 1;
            end else if (!ab_diff[W]) begin
               a_in = ab_diff[W:1];
            end else begin
               b_in = b_ff - a_ff;
               b_in = b_in >> 1;
            end
         end
      end

      if (cmd.div_init) begin
         rem_in = '0;
         cnt_in = '0;
         quo_in = (cmd.div_sel == DIV_SEL_MAG) ? mag_ff : den_ff;
      end

      // restoring divider, one quotient bit a cycle
      if (cmd.div_step) begin
         rem_in = rem_ge ? rem_sub[W-1:0] : rem_sh[W-1:0];
         quo_in = {quo_ff[W-2:0], rem_ge};
         cnt_in = cnt_ff + CNT_WIDTH'(1);
      end

      if (cmd.save_num) begin
         qnum_in = quo_ff;
      end

      if (cmd.load_out) begin
         if (g_ff == '0) begin
            out_in = '0;
         end else begin
            out_in = {quo_ff, (neg_ff ? qnum_neg : qnum_ff)};
         end
      end
   end

   always_ff @(posedge clock) begin
      a_ff    <= a_in;
      b_ff    <= b_in;
      k_ff    <= k_in;
      neg_ff  <= neg_in;
      mag_ff  <= mag_in;
      den_ff  <= den_in;
      g_ff    <= g_in;
      quo_ff  <= quo_in;
      rem_ff  <= rem_in;
      cnt_ff  <= cnt_in;
      qnum_ff <= qnum_in;
      out_ff  <= out_in;
   end

   assign out_data = out_ff;

`ifndef SYNTH
   a_div_nonzero_divisor: assert property (@(posedge clock) disable iff (reset)
      cmd.div_step |-> (g_ff != '0))
      else $error("divider stepping with zero gcd");

   a_rem_below_divisor: assert property (@(posedge clock) disable iff (reset)
      cmd.div_step |-> (rem_ff < g_ff))
      else $error("partial remainder not below divisor");

   a_div_init_clears: assert property (@(posedge clock) disable iff (reset)
      cmd.div_init |=> (cnt_ff == '0) && (rem_ff == '0))
      else $error("divider init did not clear count and remainder");
`endif

endmodule

@@ sv/fgr_controller.sv @@
`timescale 1ns / 1ps

module fgr_controller (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_tvalid,
   output logic                    req_tready,
   output logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   output fgr_pkg::fgr_cmd_type    cmd,
   input  fgr_pkg::fgr_status_type status
);
   import fgr_pkg::*;

   fgr_state_type state_ff, state_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic          out_free;

   assign out_free = !rsp_valid_ff || rsp_tready;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) state_in = S_GCD;
         end
         S_GCD: begin
            if (status.gcd_done) state_in = status.both_zero ? S_OUT : S_DIV_NUM;
         end
         S_DIV_NUM: begin
            if (status.div_last) state_in = S_SWAP;
         end
         S_SWAP: begin
            state_in = S_DIV_DEN;
         end
         S_DIV_DEN: begin
            if (status.div_last) state_in = S_OUT;
         end
         S_OUT: begin
            if (out_free) state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      cmd        = '0;
      cmd.div_sel = DIV_SEL_MAG;
      req_tready = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_tready = 1'b1;
            cmd.load   = req_tvalid;
         end
         S_GCD: begin
            cmd.gcd_step = 1'b1;
            cmd.div_init = status.gcd_done && !status.both_zero;
         end
         S_DIV_NUM: begin
            cmd.div_step = 1'b1;
         end
         S_SWAP: begin
            cmd.save_num = 1'b1;
            cmd.div_init = 1'b1;
            cmd.div_sel  = DIV_SEL_DEN;
         end
         S_DIV_DEN: begin
            cmd.div_step = 1'b1;
         end
         S_OUT: begin
            cmd.load_out = out_free;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_tready) rsp_valid_in = 1'b0;
      if (cmd.load_out) rsp_valid_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;

`ifndef SYNTH
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.load_out |-> (!rsp_valid_ff || rsp_tready))
      else $error("result register overwritten before it was taken");

   a_load_only_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.load |-> (state_ff == S_IDLE) && !cmd.div_step && !cmd.gcd_step)
      else $error("new word loaded while an item is in work");

   a_out_returns_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.load_out |=> (state_ff == S_IDLE) && rsp_tvalid)
      else $error("result load did not end the item");
`endif

endmodule
